/* hdl/bqn_pkg.sv */
// Shared types and constants for the direct-form-1 biquad notch filter.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package bqn_pkg;

  localparam int IN_W     = 16;   // sample field width
  localparam int COEF_W   = 16;   // Q2.14 coefficient width
  localparam int OUT_W    = 26;   // filtered output, 8 fraction bits
  localparam int BYTE_W   = 8;
  localparam int FF_W     = 35;   // sum of three feedforward products
  localparam int ACC_W    = 46;   // full accumulator, Q22
  localparam int RND_SH   = 14;   // Q22 -> Q8
  localparam int FF_SH    = 8;    // Q14 -> Q22
  localparam int FIFO_DEPTH = 4;
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W    = $clog2(FIFO_DEPTH);

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_B0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FB1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_FB2 = 3'd4;

  localparam logic signed [COEF_W-1:0] B0_RST  = 16'sd16181;
  localparam logic signed [COEF_W-1:0] B1_RST  = -16'sd30780;
  localparam logic signed [COEF_W-1:0] B2_RST  = 16'sd16181;
  localparam logic signed [COEF_W-1:0] FB1_RST = 16'sd30398;
  localparam logic signed [COEF_W-1:0] FB2_RST = -16'sd15779;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] fb1;
    logic signed [COEF_W-1:0] fb2;
  } coef_t;

  // queue status seen by the front end and the back end
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

/* hdl/bqn_front.sv */
// Front end: input transfer, sample masking, input history and the three
// feedforward products. Pushes one feedforward sum per sample. Uses bqn_pkg.
`timescale 1ns / 1ps

module bqn_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bqn_pkg::IN_W-1:0]     s_tdata,
  input  bqn_pkg::coef_t               coef,
  input  bqn_pkg::fifo_stat_t          stat,
  output logic                         push,
  output logic signed [bqn_pkg::FF_W-1:0] push_ff
);

  localparam int PW = bqn_pkg::COEF_W + SAMPLE_BITS + 1;
  localparam int SW = PW + 2;

  logic [SAMPLE_BITS-1:0] x;
  logic [SAMPLE_BITS-1:0] x1;
  logic [SAMPLE_BITS-1:0] x2;
  logic signed [PW-1:0]   p0;
  logic signed [PW-1:0]   p1;
  logic signed [PW-1:0]   p2;
  logic                   p_valid;
  logic                   accept;
  logic [bqn_pkg::CNT_W:0] occupancy;
  logic signed [SW-1:0]   ff_sum;

  assign x = s_tdata[SAMPLE_BITS-1:0];

  // credit check: items in the queue plus the one in the product stage
  assign occupancy = {1'b0, stat.count} + {{bqn_pkg::CNT_W{1'b0}}, p_valid};
  assign s_tready  = occupancy < (bqn_pkg::CNT_W + 1)'(bqn_pkg::FIFO_DEPTH);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      x1      <= '0;
      x2      <= '0;
    end else begin
      p_valid <= accept;
      if (accept) begin
        x1 <= x;
        x2 <= x1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0 <= coef.b0 * $signed({1'b0, x});
      p1 <= coef.b1 * $signed({1'b0, x1});
      p2 <= coef.b2 * $signed({1'b0, x2});
    end
  end

  assign ff_sum  = SW'(p0) + SW'(p1) + SW'(p2);
  assign push    = p_valid;
  assign push_ff = (bqn_pkg::FF_W)'(ff_sum);

endmodule

/* hdl/bqn_fifo.sv */
// Short queue of feedforward sums between the front and back ends.
// Uses bqn_pkg for depth and widths; the front end never pushes when full.
`timescale 1ns / 1ps

module bqn_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic signed [bqn_pkg::FF_W-1:0] push_ff,
  input  logic                            pop,
  output logic signed [bqn_pkg::FF_W-1:0] pop_ff,
  output bqn_pkg::fifo_stat_t             stat
);

  logic signed [bqn_pkg::FF_W-1:0] mem [bqn_pkg::FIFO_DEPTH];
  logic [bqn_pkg::PTR_W-1:0] wr_ptr;
  logic [bqn_pkg::PTR_W-1:0] rd_ptr;
  logic [bqn_pkg::CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_ff      = mem[rd_ptr];
  assign stat.count  = count;
  assign stat.valid  = count != '0;

endmodule

/* hdl/bqn_back.sv */
// Back end: feedback products, rounding to Q8, saturation, byte scaling,
// output history and the output register. Uses bqn_pkg.
`timescale 1ns / 1ps

module bqn_back (
  input  logic                            clk,
  input  logic                            rst,
  input  bqn_pkg::coef_t                  coef,
  input  bqn_pkg::fifo_stat_t             stat,
  input  logic signed [bqn_pkg::FF_W-1:0] pop_ff,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata
);

  localparam int OW = bqn_pkg::OUT_W;
  localparam int SH_W = bqn_pkg::FF_W + bqn_pkg::FF_SH;
  localparam int PF_W = bqn_pkg::COEF_W + OW;
  localparam int RW = bqn_pkg::ACC_W - bqn_pkg::RND_SH;
  localparam logic signed [bqn_pkg::ACC_W-1:0] RND =
    bqn_pkg::ACC_W'(1) <<< (bqn_pkg::RND_SH - 1);

  logic signed [OW-1:0] y1;
  logic signed [OW-1:0] y2;
  logic signed [OW-1:0] y;
  logic signed [SH_W-1:0] ff_sh;
  logic signed [PF_W-1:0] pf1;
  logic signed [PF_W-1:0] pf2;
  logic signed [bqn_pkg::ACC_W-1:0] acc;
  logic signed [RW-1:0] acc_r;
  logic [RW-OW:0] hi;
  logic [32:0] scaled;
  logic [bqn_pkg::BYTE_W-1:0] byte_val;
  logic [OW-1:0] out_filtered;
  logic [bqn_pkg::BYTE_W-1:0] out_byte;

  assign pop = stat.valid && (!m_tvalid || m_tready);

  assign ff_sh = $signed({pop_ff, {bqn_pkg::FF_SH{1'b0}}});
  assign pf1   = coef.fb1 * y1;
  assign pf2   = coef.fb2 * y2;
  assign acc   = bqn_pkg::ACC_W'(ff_sh) + bqn_pkg::ACC_W'(pf1)
               + bqn_pkg::ACC_W'(pf2) + RND;
  assign acc_r = RW'(acc >>> bqn_pkg::RND_SH);

  // saturate to the 26-bit range when the bits above the sign disagree
  assign hi = acc_r[RW-1:OW-1];
  always_comb begin
    if (hi == '0 || hi == '1) begin
      y = acc_r[OW-1:0];
    end else if (acc_r[RW-1]) begin
      y = {1'b1, {(OW-1){1'b0}}};
    end else begin
      y = {1'b0, {(OW-1){1'b1}}};
    end
  end

  // byte = y*255 >> 24, clamped; zero for y <= 0
  assign scaled = {y[OW-2:0], 8'b0} - {8'b0, y[OW-2:0]};
  always_comb begin
    if (y[OW-1] || y == '0) begin
      byte_val = '0;
    end else if (scaled[32]) begin
      byte_val = '1;
    end else begin
      byte_val = scaled[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      y1       <= '0;
      y2       <= '0;
    end else begin
      if (pop) begin
        m_tvalid <= 1'b1;
        y1       <= y;
        y2       <= y1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_filtered <= y;
      out_byte     <= byte_val;
    end
  end

  assign m_tdata = {6'b0, out_byte, out_filtered};

endmodule

/* hdl/biquad_notch_df1_to_byte_top.sv */
// A sample accepted at the input passes the product stage, the queue and the
// back-end output register on its way out. Throughput: one sample per cycle
// while the output is not stalled; the y1/y2 feedback loop in the back end is
// combinational between its history registers, and the four-entry queue
// absorbs output stalls. Reset (rst, synchronous) clears histories, queue and
// valids and loads the default notch coefficients.
`timescale 1ns / 1ps

module biquad_notch_df1_to_byte_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [25:0] filtered, [33:26] out_byte, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bqn_pkg::coef_t coef;
  bqn_pkg::fifo_stat_t stat;
  logic push;
  logic pop;
  logic signed [bqn_pkg::FF_W-1:0] push_ff;
  logic signed [bqn_pkg::FF_W-1:0] pop_ff;
  logic [bqn_pkg::IDX_W-1:0] idx;
  logic wr_en;
  logic signed [bqn_pkg::COEF_W-1:0] wr_coef;
  logic signed [bqn_pkg::COEF_W-1:0] rd_coef;

  assign pready  = 1'b1;
  assign idx     = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_coef = pwdata[bqn_pkg::COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0  <= bqn_pkg::B0_RST;
      coef.b1  <= bqn_pkg::B1_RST;
      coef.b2  <= bqn_pkg::B2_RST;
      coef.fb1 <= bqn_pkg::FB1_RST;
      coef.fb2 <= bqn_pkg::FB2_RST;
    end else if (wr_en) begin
      case (idx)
        bqn_pkg::REG_B0:  coef.b0  <= wr_coef;
        bqn_pkg::REG_B1:  coef.b1  <= wr_coef;
        bqn_pkg::REG_B2:  coef.b2  <= wr_coef;
        bqn_pkg::REG_FB1: coef.fb1 <= wr_coef;
        bqn_pkg::REG_FB2: coef.fb2 <= wr_coef;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bqn_pkg::REG_B0:  rd_coef = coef.b0;
      bqn_pkg::REG_B1:  rd_coef = coef.b1;
      bqn_pkg::REG_B2:  rd_coef = coef.b2;
      bqn_pkg::REG_FB1: rd_coef = coef.fb1;
      bqn_pkg::REG_FB2: rd_coef = coef.fb2;
      default:          rd_coef = '0;
    endcase
  end

  assign prdata = bqn_pkg::DATA_W'(rd_coef);

  bqn_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .coef     (coef),
    .stat     (stat),
    .push     (push),
    .push_ff  (push_ff)
  );

  bqn_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_ff (push_ff),
    .pop     (pop),
    .pop_ff  (pop_ff),
    .stat    (stat)
  );

  bqn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .stat     (stat),
    .pop_ff   (pop_ff),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
